### rtl/core/bfdh_pkg.sv
// Package with shared constants and types for the double-hash Bloom filter.
`default_nettype none
package bfdh_pkg;
    localparam int MAX_BITS   = 65536;
    localparam int MAX_PROBES = 16;
    localparam int ADDR_W     = $clog2(MAX_BITS);
    localparam int M_W        = ADDR_W + 1;
    localparam int K_W        = $clog2(MAX_PROBES) + 1;
    localparam int HASH_W     = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 17;
    localparam int IDX_W      = 1;
    localparam int QDEPTH     = 2;

    localparam logic [IDX_W-1:0] REG_BIT_COUNT   = 1'b0;
    localparam logic [IDX_W-1:0] REG_PROBE_COUNT = 1'b1;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // One classified job handed from the front to the back.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] step;
        logic [M_W-1:0]    m;
        logic [K_W-1:0]    k;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_WAIT,
        B_DONE
    } t_back_state;
endpackage
`default_nettype wire

### rtl/core/bfdh_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bfdh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read before write at the addressed word, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### rtl/core/bfdh_front.sv
// Front end: takes items, reduces a+b and b modulo m bit-serially, queues jobs.
`default_nettype none
module bfdh_front import bfdh_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_opcode,
    input  wire logic [HASH_W-1:0] i_hash_a,
    input  wire logic [HASH_W-1:0] i_hash_b,
    input  wire logic [M_W-1:0]    i_m,
    input  wire logic [K_W-1:0]    i_k,
    input  wire logic              i_q_full,
    output logic                   o_busy,
    output logic                   o_push,
    output t_job                   o_job
);
    t_front_state r_state, n_state;
    logic [HASH_W-1:0] r_sa, r_sb;
    logic [M_W-1:0]    r_ra, r_rb, r_m;
    logic [K_W-1:0]    r_k;
    logic              r_op;
    logic [6:0]        r_cnt;
    logic [M_W:0]      w_ta, w_tb;
    logic [M_W:0]      w_ma, w_mb;

    // One remainder bit per cycle for both dividends.
    always_comb begin
        w_ta = {r_ra, r_sa[HASH_W-1]};
        w_tb = {r_rb, r_sb[HASH_W-1]};
        w_ma = (w_ta >= {1'b0, r_m}) ? w_ta - {1'b0, r_m} : w_ta;
        w_mb = (w_tb >= {1'b0, r_m}) ? w_tb - {1'b0, r_m} : w_tb;
    end

    // State sequencing and handshake outputs.
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 7'd63) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: a holds a+b, b holds the step.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_sa  <= i_hash_a + i_hash_b;
            r_sb  <= i_hash_b;
            r_ra  <= '0;
            r_rb  <= '0;
            r_cnt <= '0;
            r_op  <= i_opcode;
            r_m   <= (i_m == '0) ? M_W'(1) : ((i_m > M_W'(MAX_BITS)) ? M_W'(MAX_BITS) : i_m);
            r_k   <= (i_k == '0) ? K_W'(1)
                   : ((i_k > K_W'(MAX_PROBES)) ? K_W'(MAX_PROBES) : i_k);
        end else if (r_state == S_DIV) begin
            r_sa  <= {r_sa[HASH_W-2:0], 1'b0};
            r_sb  <= {r_sb[HASH_W-2:0], 1'b0};
            r_ra  <= w_ma[M_W-1:0];
            r_rb  <= w_mb[M_W-1:0];
            r_cnt <= r_cnt + 7'd1;
        end
    end

    assign o_job.op   = r_op;
    assign o_job.pos  = r_ra[ADDR_W-1:0];
    assign o_job.step = r_rb[ADDR_W-1:0];
    assign o_job.m    = r_m;
    assign o_job.k    = r_k;
endmodule
`default_nettype wire

### rtl/core/bfdh_queue.sv
// Short job queue between the front and the back.
`default_nettype none
module bfdh_queue import bfdh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);
    localparam int PW = $clog2(QDEPTH);
    t_job         r_buf [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_buf[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

### rtl/core/bfdh_back.sv
// Back end: walks the probes through the bit store and issues results.
`default_nettype none
module bfdh_back import bfdh_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire t_job             i_job,
    output logic                  o_pop,
    output logic                  o_clear,
    output logic                  o_done,
    output logic                  o_maybe_present,
    output logic [CNT_W-1:0]      o_items_inserted
);
    t_back_state r_state, n_state;
    t_job              r_job;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_clr;
    logic [K_W-1:0]    r_i;
    logic              r_all;
    logic [CNT_W-1:0]  r_count;
    logic              w_clear;
    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic              w_rdata;
    logic [M_W:0]      w_sum;
    logic [ADDR_W-1:0] w_next;

    assign w_sum  = {2'b00, r_pos} + {2'b00, r_job.step};
    assign w_next = (w_sum >= {1'b0, r_job.m}) ? ADDR_W'(w_sum - {1'b0, r_job.m})
                                               : ADDR_W'(w_sum);

    // The clearing pass after reset zeroes one store bit per cycle.
    assign w_clear = (r_state == B_CLEAR);
    assign w_we    = w_clear || ((r_state == B_PROBE) && (r_job.op == OP_INSERT));
    assign w_addr  = w_clear ? r_clr : r_pos;
    assign o_clear = w_clear;

    bfdh_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (!w_clear),
        .o_rdata (w_rdata)
    );

    // Probe sequencing: each probe passes B_PROBE, then B_WAIT.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            B_CLEAR: n_state = (r_clr == '1) ? B_IDLE : B_CLEAR;
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_PROBE;
                end
            end
            B_PROBE: n_state = B_WAIT;
            B_WAIT:  n_state = (r_i == r_job.k) ? B_DONE : B_PROBE;
            B_DONE: begin
                o_done  = 1'b1;
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (r_state == B_WAIT && r_i == r_job.k && r_job.op == OP_INSERT) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Probe position, counter and all-set flag.
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_empty) begin
            r_job <= i_job;
            r_pos <= i_job.pos;
            r_i   <= K_W'(1);
            r_all <= 1'b1;
        end else if (r_state == B_WAIT) begin
            if (!w_rdata) r_all <= 1'b0;
            if (r_i != r_job.k) begin
                r_pos <= w_next;
                r_i   <= r_i + K_W'(1);
            end
        end
    end

    assign o_maybe_present  = (r_job.op == OP_INSERT) ? 1'b1 : r_all;
    assign o_items_inserted = r_count;
endmodule
`default_nettype wire

### rtl/core/bloom_filter_double_hash.sv
// Top level of the double-hash Bloom filter.
// In the front an item is loaded, a+b and b are reduced modulo m bit-serially
// and the job is handed off; in the back each probe makes a bit-store access
// and its registered read. The front's serial divider sets the sustained
// rate, and the front takes no new item until its job is handed off.
// A two-entry queue lets the front reduce the next item while the back probes.
// Each result appears for one cycle on o_done and cannot be held off. The
// 64K-bit store comes out of reset undefined: after reset the block clears it
// in a pass over every bit and holds busy high meanwhile.
`default_nettype none
module bloom_filter_double_hash import bfdh_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_opcode,
    input  wire logic [HASH_W-1:0] i_hash_a,
    input  wire logic [HASH_W-1:0] i_hash_b,
    output logic                   o_done,
    output logic                   o_maybe_present,
    output logic [CNT_W-1:0]       o_items_inserted
);
    logic [M_W-1:0] r_bit_count;
    logic [K_W-1:0] r_probe_count;
    logic           w_push, w_pop, w_full, w_empty, w_fbusy, w_clear;
    t_job           w_qin, w_qout;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= M_W'(65536);
            r_probe_count <= K_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BIT_COUNT:   r_bit_count   <= i_cfg_data[M_W-1:0];
                REG_PROBE_COUNT: r_probe_count <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    bfdh_front u_front (
        .i_clk, .i_rst_n,
        .i_start  (start && !w_clear),
        .i_opcode, .i_hash_a, .i_hash_b,
        .i_m      (r_bit_count),
        .i_k      (r_probe_count),
        .i_q_full (w_full),
        .o_busy   (w_fbusy),
        .o_push   (w_push),
        .o_job    (w_qin)
    );

    bfdh_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (w_push),
        .i_job   (w_qin),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_qout)
    );

    bfdh_back u_back (
        .i_clk, .i_rst_n,
        .i_empty          (w_empty),
        .i_job            (w_qout),
        .o_pop            (w_pop),
        .o_clear          (w_clear),
        .o_done,
        .o_maybe_present,
        .o_items_inserted
    );

    // No transfer is taken while the store is being cleared.
    assign busy = w_fbusy || w_clear;
endmodule
`default_nettype wire

### rtl/core/bfdh_checker.sv
// Port-level checker for the Bloom filter, bound to the top level.
`default_nettype none
module bfdh_checker import bfdh_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_done,
    input wire logic             o_maybe_present,
    input wire logic [CNT_W-1:0] o_items_inserted
);
    // Count moves only with a result.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_done) && !o_done |-> $stable(o_items_inserted))
        else $error("insert count changed without a result");
    // An accepted item makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a transfer");
    // Results are single-cycle strobes.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    // A result transfer carries known values.
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown({o_maybe_present, o_items_inserted}))
        else $error("result fields unknown during a transfer");
endmodule

bind bloom_filter_double_hash bfdh_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_maybe_present, .o_items_inserted
);
`default_nettype wire
